[design/ldo_pkg.sv]
`default_nettype none

package ldo_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [2:0] CSR_GAIN_POSITION        = 3'd0;
   localparam logic [2:0] CSR_GAIN_RATE            = 3'd1;
   localparam logic [2:0] CSR_GAIN_ACCEL           = 3'd2;
   localparam logic [2:0] CSR_FILTER_TIME_CONSTANT = 3'd3;
   localparam logic [2:0] CSR_CLAMP_LIMIT          = 3'd4;
   localparam logic [2:0] CSR_DEADBAND_FRACTION    = 3'd5;

endpackage

`default_nettype wire

[design/linear_disturbance_observer_top.sv]
// Linear disturbance observer with a first-order low-pass filter on the estimate.
// Input beats (req_*) carry a measurement, the applied control effort and the elapsed
// time; every accepted input beat produces exactly one result beat (rsp_*) holding
// the deadbanded compensation and the clamped disturbance estimate.
// Gains, filter time constant, clamp limit and deadband are set through the APB-style
// port, which must only be written while no beat is in flight.
// One shared restoring divider (one quotient bit per cycle) and one shared multiplier
// do all the arithmetic under a small sequencer. Each derivative that saturates skips
// its division. The next input beat can be taken in the cycle after the result is
// loaded into the output register. req_stall is high while a beat is being worked
// on.
// A finished result waits in the output register while rsp_stall is high; a second
// finished result waits inside the block until the register frees.
// Synchronous reset clears the configuration registers to zero, the previous
// measurement, rate and estimate to zero, and drops rsp_valid.
`default_nettype none

module linear_disturbance_observer_top #(
   parameter int DATA_WIDTH = ldo_pkg::DATA_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = ldo_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [31:0]                   req_measurement,
   input  wire logic signed [31:0]                   req_control_effort,
   input  wire logic [16:0]                          req_elapsed_time,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [31:0]                        rsp_compensation,
   output logic signed [31:0]                        rsp_disturbance_estimate,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [ldo_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire logic [ldo_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [ldo_pkg::CSR_DATA_WIDTH-1:0]        prdata,
   output logic                                      pready
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int AW = (W > 17) ? W : 17;
   localparam int PW = AW + 32;
   localparam int EW = PW + 2;
   localparam int NW = W + 32;
   localparam int OW = W + F + 18;
   localparam int BW = PW + 17;
   localparam int CW = $clog2(W);

   localparam logic signed [W-1:0]  DMAX = $signed({1'b0, {(W-1){1'b1}}});
   localparam logic signed [W-1:0]  DMIN = $signed({1'b1, {(W-1){1'b0}}});
   localparam logic signed [EW-1:0] EMAX = EW'(DMAX);
   localparam logic signed [EW-1:0] EMIN = EW'(DMIN);

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_RATE_SET = 5'd1;
   localparam logic [4:0] ST_RATE_DIV = 5'd2;
   localparam logic [4:0] ST_ACC_SET  = 5'd3;
   localparam logic [4:0] ST_ACC_DIV  = 5'd4;
   localparam logic [4:0] ST_MUL_P    = 5'd5;
   localparam logic [4:0] ST_ADD_P    = 5'd6;
   localparam logic [4:0] ST_MUL_R    = 5'd7;
   localparam logic [4:0] ST_ADD_R    = 5'd8;
   localparam logic [4:0] ST_MUL_A    = 5'd9;
   localparam logic [4:0] ST_ADD_A    = 5'd10;
   localparam logic [4:0] ST_RAW      = 5'd11;
   localparam logic [4:0] ST_F0_MUL   = 5'd12;
   localparam logic [4:0] ST_F0_SET   = 5'd13;
   localparam logic [4:0] ST_F0_DIV   = 5'd14;
   localparam logic [4:0] ST_F1_MUL   = 5'd15;
   localparam logic [4:0] ST_F1_SET   = 5'd16;
   localparam logic [4:0] ST_F1_DIV   = 5'd17;
   localparam logic [4:0] ST_CLAMP    = 5'd18;
   localparam logic [4:0] ST_DB_MUL   = 5'd19;
   localparam logic [4:0] ST_DB_OUT   = 5'd20;

   function automatic logic signed [W-1:0] sat_ew(input logic signed [EW-1:0] v);
      logic signed [W-1:0] r;
      if (v > EMAX) begin
         r = DMAX;
      end else if (v < EMIN) begin
         r = DMIN;
      end else begin
         r = $signed(v[W-1:0]);
      end
      return r;
   endfunction

   function automatic logic signed [W-1:0] mag_sat(input logic neg, input logic [PW-1:0] m);
      logic signed [EW-1:0] e;
      e = $signed({2'b00, m});
      if (neg) begin
         e = -e;
      end
      return sat_ew(e);
   endfunction

   function automatic logic [W-1:0] abs_w(input logic signed [W-1:0] v);
      logic [W-1:0] r;
      r = v[W-1] ? -v : v;
      return r;
   endfunction

   function automatic logic [31:0] abs_32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? -v : v;
      return r;
   endfunction

   // Configuration registers.
   logic signed [31:0] gain_position_ff, gain_position_in;
   logic signed [31:0] gain_rate_ff, gain_rate_in;
   logic signed [31:0] gain_accel_ff, gain_accel_in;
   logic [30:0]        filter_time_constant_ff, filter_time_constant_in;
   logic [30:0]        clamp_limit_ff, clamp_limit_in;
   logic [16:0]        deadband_fraction_ff, deadband_fraction_in;

   // Sequencer and datapath registers.
   logic [4:0]          state_ff, state_in;
   logic signed [W-1:0] meas_ff, meas_in;
   logic [16:0]         dt_ff, dt_in;
   logic signed [W-1:0] rate_ff, rate_in;
   logic signed [W-1:0] accel_ff, accel_in;
   logic signed [W-1:0] raw_ff, raw_in;
   logic signed [W-1:0] dist_ff, dist_in;
   logic signed [EW-1:0] acc_ff, acc_in;
   logic signed [W-1:0] prev_meas_ff, prev_meas_in;
   logic signed [W-1:0] prev_rate_ff, prev_rate_in;
   logic signed [W-1:0] prev_dist_ff, prev_dist_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic                mul_neg_ff, mul_neg_in;
   logic [31:0]         div_rem_ff, div_rem_in;
   logic [W-1:0]        div_q_ff, div_q_in;
   logic [31:0]         div_den_ff, div_den_in;
   logic                div_neg_ff, div_neg_in;
   logic [CW-1:0]       div_cnt_ff, div_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_comp_ff, rsp_comp_in;
   logic signed [31:0]  rsp_est_ff, rsp_est_in;

   logic                 cfg_write;
   logic [AW-1:0]        mul_a;
   logic [31:0]          mul_b;
   logic                 mul_neg;
   logic signed [W-1:0]  diff_a;
   logic signed [W-1:0]  diff_b;
   logic signed [W:0]    diff;
   logic [W:0]           diff_mag;
   logic                 diff_ovf;
   logic [NW-1:0]        diff_dividend;
   logic [32:0]          div_trial;
   logic                 div_ge;
   logic [31:0]          div_rem_next;
   logic [W-1:0]         div_q_next;
   logic                 div_last;
   logic signed [W-1:0]  div_result;
   logic signed [W-1:0]  mul_result;
   logic [31:0]          filter_den;
   logic signed [EW-1:0] clamp_s;
   logic signed [EW-1:0] clamp_lim;
   logic signed [EW-1:0] clamp_c;
   logic                 db_pass;
   logic signed [W-1:0]  comp_w;
   logic signed [EW-1:0] comp_e;
   logic signed [EW-1:0] est_e;
   logic signed [EW-1:0] meas_e;
   logic signed [EW-1:0] effort_e;

   assign cfg_write = psel & penable & pwrite & pready;
   assign pready    = 1'b1;

   always_comb begin
      case (paddr[4:2])
         ldo_pkg::CSR_GAIN_POSITION:        prdata = gain_position_ff;
         ldo_pkg::CSR_GAIN_RATE:            prdata = gain_rate_ff;
         ldo_pkg::CSR_GAIN_ACCEL:           prdata = gain_accel_ff;
         ldo_pkg::CSR_FILTER_TIME_CONSTANT: prdata = {1'b0, filter_time_constant_ff};
         ldo_pkg::CSR_CLAMP_LIMIT:          prdata = {1'b0, clamp_limit_ff};
         ldo_pkg::CSR_DEADBAND_FRACTION:    prdata = {15'd0, deadband_fraction_ff};
         default:                           prdata = '0;
      endcase
   end

   always_comb begin
      gain_position_in        = gain_position_ff;
      gain_rate_in            = gain_rate_ff;
      gain_accel_in           = gain_accel_ff;
      filter_time_constant_in = filter_time_constant_ff;
      clamp_limit_in          = clamp_limit_ff;
      deadband_fraction_in    = deadband_fraction_ff;
      if (cfg_write) begin
         case (paddr[4:2])
            ldo_pkg::CSR_GAIN_POSITION:        gain_position_in = $signed(pwdata);
            ldo_pkg::CSR_GAIN_RATE:            gain_rate_in = $signed(pwdata);
            ldo_pkg::CSR_GAIN_ACCEL:           gain_accel_in = $signed(pwdata);
            ldo_pkg::CSR_FILTER_TIME_CONSTANT: filter_time_constant_in = pwdata[30:0];
            ldo_pkg::CSR_CLAMP_LIMIT:          clamp_limit_in = pwdata[30:0];
            ldo_pkg::CSR_DEADBAND_FRACTION:    deadband_fraction_in = pwdata[16:0];
            default: begin
            end
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (state_ff)
         ST_MUL_P: begin
            mul_a   = AW'(abs_w(meas_ff));
            mul_b   = abs_32(gain_position_ff);
            mul_neg = meas_ff[W-1] ^ gain_position_ff[31];
         end
         ST_MUL_R: begin
            mul_a   = AW'(abs_w(rate_ff));
            mul_b   = abs_32(gain_rate_ff);
            mul_neg = rate_ff[W-1] ^ gain_rate_ff[31];
         end
         ST_MUL_A: begin
            mul_a   = AW'(abs_w(accel_ff));
            mul_b   = abs_32(gain_accel_ff);
            mul_neg = accel_ff[W-1] ^ gain_accel_ff[31];
         end
         ST_F0_MUL: begin
            mul_a   = AW'(abs_w(raw_ff));
            mul_b   = {15'd0, dt_ff};
            mul_neg = raw_ff[W-1];
         end
         ST_F1_MUL: begin
            mul_a   = AW'(abs_w(prev_dist_ff));
            mul_b   = {1'b0, filter_time_constant_ff};
            mul_neg = prev_dist_ff[W-1];
         end
         ST_DB_MUL: begin
            mul_a   = AW'(deadband_fraction_ff);
            mul_b   = {1'b0, clamp_limit_ff};
            mul_neg = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Backward difference and divider setup for the two derivatives.
   always_comb begin
      if (state_ff == ST_ACC_SET) begin
         diff_a = rate_ff;
         diff_b = prev_rate_ff;
      end else begin
         diff_a = meas_ff;
         diff_b = prev_meas_ff;
      end
      diff          = {diff_a[W-1], diff_a} - {diff_b[W-1], diff_b};
      diff_mag      = diff[W] ? -diff : diff;
      diff_ovf      = (OW'(diff_mag) << F) >= (OW'(dt_ff) << (W - 1));
      diff_dividend = NW'(diff_mag) << F;
   end

   // One restoring step of the shared divider.
   always_comb begin
      div_trial    = {div_rem_ff, div_q_ff[W-1]};
      div_ge       = div_trial >= {1'b0, div_den_ff};
      div_rem_next = div_ge ? 32'(div_trial - {1'b0, div_den_ff}) : div_trial[31:0];
      div_q_next   = {div_q_ff[W-2:0], div_ge};
      div_last     = div_cnt_ff == CW'(W - 1);
      div_result   = mag_sat(div_neg_ff, PW'(div_q_next));
   end

   assign mul_result = mag_sat(mul_neg_ff, prod_ff >> F);
   assign filter_den = {15'd0, dt_ff} + {1'b0, filter_time_constant_ff};

   always_comb begin
      clamp_s   = EW'(sat_ew(acc_ff));
      clamp_lim = $signed(EW'({1'b0, clamp_limit_ff}));
      clamp_c   = clamp_s;
      if (clamp_s > clamp_lim) begin
         clamp_c = clamp_lim;
      end
      if (clamp_s < -clamp_lim) begin
         clamp_c = -clamp_lim;
      end
   end

   always_comb begin
      db_pass  = (BW'(abs_w(dist_ff)) << 16) > BW'(prod_ff);
      comp_w   = db_pass ? dist_ff : '0;
      comp_e   = EW'(comp_w);
      est_e    = EW'(dist_ff);
      meas_e   = EW'(req_measurement);
      effort_e = EW'(req_control_effort);
   end

   always_comb begin
      state_in     = state_ff;
      meas_in      = meas_ff;
      dt_in        = dt_ff;
      rate_in      = rate_ff;
      accel_in     = accel_ff;
      raw_in       = raw_ff;
      dist_in      = dist_ff;
      acc_in       = acc_ff;
      prev_meas_in = prev_meas_ff;
      prev_rate_in = prev_rate_ff;
      prev_dist_in = prev_dist_ff;
      prod_in      = prod_ff;
      mul_neg_in   = mul_neg_ff;
      div_rem_in   = div_rem_ff;
      div_q_in     = div_q_ff;
      div_den_in   = div_den_ff;
      div_neg_in   = div_neg_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_comp_in  = rsp_comp_ff;
      rsp_est_in   = rsp_est_ff;

      case (state_ff)
         ST_MUL_P, ST_MUL_R, ST_MUL_A, ST_F0_MUL, ST_F1_MUL, ST_DB_MUL: begin
            prod_in    = PW'(mul_a) * PW'(mul_b);
            mul_neg_in = mul_neg;
         end
         default: begin
         end
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in  = sat_ew(meas_e);
               acc_in   = -EW'(sat_ew(effort_e));
               dt_in    = (req_elapsed_time == '0) ? 17'd1 : req_elapsed_time;
               state_in = ST_RATE_SET;
            end
         end
         ST_RATE_SET, ST_ACC_SET: begin
            div_rem_in = diff_dividend[NW-1:W];
            div_q_in   = diff_dividend[W-1:0];
            div_den_in = {15'd0, dt_ff};
            div_neg_in = diff[W];
            div_cnt_in = '0;
            if (state_ff == ST_RATE_SET) begin
               if (diff_ovf) begin
                  rate_in  = diff[W] ? DMIN : DMAX;
                  state_in = ST_ACC_SET;
               end else begin
                  state_in = ST_RATE_DIV;
               end
            end else begin
               if (diff_ovf) begin
                  accel_in = diff[W] ? DMIN : DMAX;
                  state_in = ST_MUL_P;
               end else begin
                  state_in = ST_ACC_DIV;
               end
            end
         end
         ST_RATE_DIV, ST_ACC_DIV, ST_F0_DIV, ST_F1_DIV: begin
            div_rem_in = div_rem_next;
            div_q_in   = div_q_next;
            div_cnt_in = div_cnt_ff + CW'(1);
            if (div_last) begin
               case (state_ff)
                  ST_RATE_DIV: begin
                     rate_in  = div_result;
                     state_in = ST_ACC_SET;
                  end
                  ST_ACC_DIV: begin
                     accel_in = div_result;
                     state_in = ST_MUL_P;
                  end
                  ST_F0_DIV: begin
                     acc_in   = acc_ff + EW'(div_result);
                     state_in = ST_F1_MUL;
                  end
                  default: begin
                     acc_in   = acc_ff + EW'(div_result);
                     state_in = ST_CLAMP;
                  end
               endcase
            end
         end
         ST_MUL_P:  state_in = ST_ADD_P;
         ST_MUL_R:  state_in = ST_ADD_R;
         ST_MUL_A:  state_in = ST_ADD_A;
         ST_ADD_P, ST_ADD_R, ST_ADD_A: begin
            acc_in = acc_ff + EW'(mul_result);
            if (state_ff == ST_ADD_P) begin
               state_in = ST_MUL_R;
            end else if (state_ff == ST_ADD_R) begin
               state_in = ST_MUL_A;
            end else begin
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            raw_in   = sat_ew(acc_ff);
            acc_in   = '0;
            state_in = ST_F0_MUL;
         end
         ST_F0_MUL: state_in = ST_F0_SET;
         ST_F1_MUL: state_in = ST_F1_SET;
         ST_F0_SET, ST_F1_SET: begin
            div_rem_in = prod_ff[NW-1:W];
            div_q_in   = prod_ff[W-1:0];
            div_den_in = filter_den;
            div_neg_in = mul_neg_ff;
            div_cnt_in = '0;
            state_in   = (state_ff == ST_F0_SET) ? ST_F0_DIV : ST_F1_DIV;
         end
         ST_CLAMP: begin
            dist_in  = sat_ew(clamp_c);
            state_in = ST_DB_MUL;
         end
         ST_DB_MUL: state_in = ST_DB_OUT;
         ST_DB_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_comp_in  = $signed(comp_e[31:0]);
               rsp_est_in   = $signed(est_e[31:0]);
               prev_meas_in = meas_ff;
               prev_rate_in = rate_ff;
               prev_dist_in = dist_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_position_ff        <= '0;
         gain_rate_ff            <= '0;
         gain_accel_ff           <= '0;
         filter_time_constant_ff <= '0;
         clamp_limit_ff          <= '0;
         deadband_fraction_ff    <= '0;
         state_ff                <= ST_IDLE;
         prev_meas_ff            <= '0;
         prev_rate_ff            <= '0;
         prev_dist_ff            <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         gain_position_ff        <= gain_position_in;
         gain_rate_ff            <= gain_rate_in;
         gain_accel_ff           <= gain_accel_in;
         filter_time_constant_ff <= filter_time_constant_in;
         clamp_limit_ff          <= clamp_limit_in;
         deadband_fraction_ff    <= deadband_fraction_in;
         state_ff                <= state_in;
         prev_meas_ff            <= prev_meas_in;
         prev_rate_ff            <= prev_rate_in;
         prev_dist_ff            <= prev_dist_in;
         rsp_valid_ff            <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      dt_ff       <= dt_in;
      rate_ff     <= rate_in;
      accel_ff    <= accel_in;
      raw_ff      <= raw_in;
      dist_ff     <= dist_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      mul_neg_ff  <= mul_neg_in;
      div_rem_ff  <= div_rem_in;
      div_q_ff    <= div_q_in;
      div_den_ff  <= div_den_in;
      div_neg_ff  <= div_neg_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_comp_ff <= rsp_comp_in;
      rsp_est_ff  <= rsp_est_in;
   end

   assign req_stall                = state_ff != ST_IDLE;
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_compensation         = rsp_comp_ff;
   assign rsp_disturbance_estimate = rsp_est_ff;

endmodule

`default_nettype wire

[verif/linear_disturbance_observer_top_tb.sv]
`timescale 1ns / 100ps

module linear_disturbance_observer_top_tb;

   localparam int     FRAC     = ldo_pkg::FRAC_BITS_DEFAULT;
   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] compensation;
      logic signed [31:0] estimate;
   } estimate_beat_type;

   typedef struct {
      logic signed [31:0] gain_position;
      logic signed [31:0] gain_rate;
      logic signed [31:0] gain_accel;
      logic [30:0]        time_constant;
      logic [30:0]        clamp_limit;
      logic [16:0]        deadband;
   } observer_settings_type;

   typedef struct {
      int                 setting;
      logic signed [31:0] measurement;
      logic signed [31:0] effort;
      logic [16:0]        dt;
      bit                 known;
      logic signed [31:0] compensation;
      logic signed [31:0] estimate;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   wire                req_stall;
   logic signed [31:0] req_measurement = '0;
   logic signed [31:0] req_control_effort = '0;
   logic [16:0]        req_elapsed_time = '0;
   wire                rsp_valid;
   logic               rsp_stall = 1'b0;
   wire signed [31:0]  rsp_compensation;
   wire signed [31:0]  rsp_disturbance_estimate;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [ldo_pkg::CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [ldo_pkg::CSR_DATA_WIDTH-1:0] pwdata = '0;
   wire  [ldo_pkg::CSR_DATA_WIDTH-1:0] prdata;
   wire                pready;

   observer_settings_type model_settings = '{default: '0};
   longint             last_measurement = 0;
   longint             last_rate = 0;
   longint             last_estimate = 0;
   estimate_beat_type  expected_estimates [$];
   int                 mismatch_count = 0;
   bit                 hold_results_request = 1'b0;
   bit                 no_idle = 1'b0;
   longint             track_position = 0;

   observer_settings_type directed_settings [5] = '{
      '{32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd0, 17'd0},
      '{32'sd65536, 32'sd32768, 32'sd6554, 31'd6554, 31'd6553600, 17'd6554},
      '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 31'h7fffffff,
        17'd131071},
      '{32'sh7fffffff, 32'sd0, 32'sh7fffffff, 31'd0, 31'h7fffffff, 17'd0},
      '{32'sd65536, 32'sd0, 32'sd0, 31'd0, 31'd65536, 17'd32768}
   };

   directed_row_type directed_rows [24] = '{
      '{0, 32'sd0, 32'sd0, 17'd65536, 1'b1, 32'sd0, 32'sd0},
      '{0, 32'sh7fffffff, 32'sh80000000, 17'd1, 1'b1, 32'sd0, 32'sd0},
      '{0, 32'sh80000000, 32'sh7fffffff, 17'd131071, 1'b1, 32'sd0, 32'sd0},
      '{0, 32'sh80000000, 32'sh80000000, 17'd0, 1'b1, 32'sd0, 32'sd0},
      '{0, 32'sd12345678, -32'sd5000, 17'd655, 1'b1, 32'sd0, 32'sd0},
      '{1, 32'sd65536, 32'sd0, 17'd6554, 1'b0, 32'sd0, 32'sd0},
      '{1, 32'sd131072, 32'sd16384, 17'd6554, 1'b0, 32'sd0, 32'sd0},
      '{1, 32'sd229376, -32'sd16384, 17'd6554, 1'b0, 32'sd0, 32'sd0},
      '{1, 32'sd229376, 32'sd0, 17'd0, 1'b0, 32'sd0, 32'sd0},
      '{1, 32'sd196608, 32'sd65536, 17'd65536, 1'b0, 32'sd0, 32'sd0},
      '{1, -32'sd327680, 32'sd0, 17'd131071, 1'b0, 32'sd0, 32'sd0},
      '{2, 32'sh7fffffff, 32'sh80000000, 17'd1, 1'b0, 32'sd0, 32'sd0},
      '{2, 32'sh80000000, 32'sh7fffffff, 17'd1, 1'b0, 32'sd0, 32'sd0},
      '{2, 32'sh7fffffff, 32'sd0, 17'd131071, 1'b0, 32'sd0, 32'sd0},
      '{2, 32'sd0, 32'sh7fffffff, 17'd65536, 1'b0, 32'sd0, 32'sd0},
      '{3, 32'sh80000000, 32'sd0, 17'd1, 1'b0, 32'sd0, 32'sd0},
      '{3, 32'sh7fffffff, 32'sh80000000, 17'd131071, 1'b0, 32'sd0, 32'sd0},
      '{3, 32'sd0, 32'sd0, 17'd65536, 1'b0, 32'sd0, 32'sd0},
      '{3, 32'sd1, -32'sd1, 17'd1, 1'b0, 32'sd0, 32'sd0},
      '{4, 32'sd32768, 32'sd0, 17'd65536, 1'b0, 32'sd0, 32'sd0},
      '{4, 32'sd32769, 32'sd0, 17'd65536, 1'b0, 32'sd0, 32'sd0},
      '{4, -32'sd32769, 32'sd0, 17'd65536, 1'b0, 32'sd0, 32'sd0},
      '{4, 32'sd0, -32'sd200000, 17'd65536, 1'b0, 32'sd0, 32'sd0},
      '{4, 32'sd0, 32'sd200000, 17'd65536, 1'b0, 32'sd0, 32'sd0}
   };

   linear_disturbance_observer_top dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_measurement          (req_measurement),
      .req_control_effort       (req_control_effort),
      .req_elapsed_time         (req_elapsed_time),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_compensation         (rsp_compensation),
      .rsp_disturbance_estimate (rsp_disturbance_estimate),
      .psel                     (psel),
      .penable                  (penable),
      .pwrite                   (pwrite),
      .paddr                    (paddr),
      .pwdata                   (pwdata),
      .prdata                   (prdata),
      .pready                   (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint clamp_word(input longint v);
      return (v > WORD_MAX) ? WORD_MAX : ((v < WORD_MIN) ? WORD_MIN : v);
   endfunction

   function automatic logic [63:0] magnitude(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint from_magnitude(input bit neg, input logic [63:0] m);
      if (!neg) begin
         return (m > 64'd2147483647) ? WORD_MAX : longint'(m);
      end
      if (m > 64'd2147483648) begin
         return WORD_MIN;
      end
      return -longint'(m);
   endfunction

   function automatic longint q_mul(input longint a, input longint b);
      logic [127:0] product;
      bit           neg;
      neg = (a < 0) != (b < 0);
      product = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> FRAC;
      if (product[127:64] != '0) begin
         return neg ? WORD_MIN : WORD_MAX;
      end
      return from_magnitude(neg, product[63:0]);
   endfunction

   function automatic longint q_div(input longint num, input logic [63:0] den);
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] r;
      m = magnitude(num);
      q = m / den;
      r = m % den;
      if ((q >> (62 - FRAC)) != 0) begin
         return (num < 0) ? WORD_MIN : WORD_MAX;
      end
      return from_magnitude(num < 0, (q << FRAC) + ((r << FRAC) / den));
   endfunction

   function automatic longint scale_ratio(input longint a, input logic [63:0] b,
                                          input logic [63:0] c);
      logic [63:0] m;
      m = magnitude(a);
      return from_magnitude(a < 0, (m / c) * b + ((m % c) * b) / c);
   endfunction

   function automatic estimate_beat_type estimate_disturbance(
      input logic signed [31:0] meas,
      input logic signed [31:0] effort,
      input logic [16:0] dt);
      longint            m;
      longint            u;
      longint            rate;
      longint            accel;
      longint            raw;
      longint            d;
      longint            lim;
      longint            comp;
      logic [63:0]       interval;
      logic [63:0]       den;
      estimate_beat_type beat;
      m = longint'(meas);
      u = longint'(effort);
      interval = (dt == '0) ? 64'd1 : {47'd0, dt};
      rate = q_div(m - last_measurement, interval);
      accel = q_div(rate - last_rate, interval);
      raw = clamp_word(q_mul(longint'($signed(model_settings.gain_position)), m)
                       + q_mul(longint'($signed(model_settings.gain_rate)), rate)
                       + q_mul(longint'($signed(model_settings.gain_accel)), accel) - u);
      den = {33'd0, model_settings.time_constant} + interval;
      d = clamp_word(scale_ratio(raw, interval, den)
                     + scale_ratio(last_estimate, {33'd0, model_settings.time_constant}, den));
      lim = longint'({33'd0, model_settings.clamp_limit});
      if (d > lim) begin
         d = lim;
      end
      if (d < -lim) begin
         d = -lim;
      end
      if ((magnitude(d) << 16) >
          ({47'd0, model_settings.deadband} * {33'd0, model_settings.clamp_limit})) begin
         comp = d;
      end else begin
         comp = 0;
      end
      last_measurement = m;
      last_rate = rate;
      last_estimate = d;
      beat.compensation = comp[31:0];
      beat.estimate = d[31:0];
      return beat;
   endfunction

   function automatic logic signed [31:0] random_gain();
      case ($urandom_range(0, 5))
         0: return 32'sh80000000;
         1: return 32'sh7fffffff;
         2: return 32'sd0;
         5: return $urandom;
         default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
      endcase
   endfunction

   function automatic observer_settings_type random_settings();
      observer_settings_type s;
      s.gain_position = random_gain();
      s.gain_rate = random_gain();
      s.gain_accel = random_gain();
      case ($urandom_range(0, 4))
         0: s.time_constant = 31'd0;
         1: s.time_constant = 31'h7fffffff;
         2: s.time_constant = 31'($urandom);
         default: s.time_constant = 31'($urandom_range(1, 4 * 65536));
      endcase
      case ($urandom_range(0, 5))
         0: s.clamp_limit = 31'h7fffffff;
         1: s.clamp_limit = 31'd0;
         2: s.clamp_limit = 31'($urandom);
         default: s.clamp_limit = 31'($urandom_range(65536, 2000 * 65536));
      endcase
      case ($urandom_range(0, 5))
         0: s.deadband = 17'd0;
         1: s.deadband = 17'd65536;
         2: s.deadband = 17'd131071;
         3: s.deadband = 17'($urandom_range(0, 65536));
         4: s.deadband = 17'($urandom_range(0, 131071));
         default: s.deadband = 17'($urandom_range(0, 16384));
      endcase
      return s;
   endfunction

   task automatic next_random_beat(output logic signed [31:0] meas,
                                   output logic signed [31:0] effort,
                                   output logic [16:0] dt);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
         track_position += int'($urandom_range(0, 1 << 17)) - (1 << 16);
      end else if (pick < 19) begin
         track_position = longint'($signed($urandom));
      end else begin
         track_position = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      end
      track_position = clamp_word(track_position);
      meas = track_position[31:0];
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         effort = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      end else if (pick < 9) begin
         effort = $urandom;
      end else begin
         effort = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      end
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
         dt = 17'($urandom_range(655, 65536));
      end else if (pick < 19) begin
         dt = 17'($urandom_range(0, 131071));
      end else begin
         case ($urandom_range(0, 3))
            0: dt = 17'd0;
            1: dt = 17'd1;
            2: dt = 17'd65536;
            default: dt = 17'd131071;
         endcase
      end
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic apply_settings(input observer_settings_type s);
      write_register(ldo_pkg::CSR_GAIN_POSITION, s.gain_position);
      write_register(ldo_pkg::CSR_GAIN_RATE, s.gain_rate);
      write_register(ldo_pkg::CSR_GAIN_ACCEL, s.gain_accel);
      write_register(ldo_pkg::CSR_FILTER_TIME_CONSTANT, {1'b0, s.time_constant});
      write_register(ldo_pkg::CSR_CLAMP_LIMIT, {1'b0, s.clamp_limit});
      write_register(ldo_pkg::CSR_DEADBAND_FRACTION, {15'd0, s.deadband});
      model_settings = s;
   endtask

   task automatic send_beat(input logic signed [31:0] meas, input logic signed [31:0] effort,
                            input logic [16:0] dt, input bit known,
                            input logic signed [31:0] known_comp,
                            input logic signed [31:0] known_estimate);
      int                gap;
      estimate_beat_type beat;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_measurement <= meas;
      req_control_effort <= effort;
      req_elapsed_time <= dt;
      do @(posedge clock); while (req_stall);
      beat = estimate_disturbance(meas, effort, dt);
      if (known) begin
         beat.compensation = known_comp;
         beat.estimate = known_estimate;
      end
      expected_estimates.push_back(beat);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_estimates.size() != 0) @(posedge clock);
   endtask

   initial begin : result_sink
      int                hold;
      estimate_beat_type want;
      do @(posedge clock); while (reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 7);
         if (hold_results_request) begin
            hold_results_request = 1'b0;
            hold = 1000;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            repeat (hold - 1) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (expected_estimates.size() == 0) begin
            mismatch_count++;
            $error("result beat with nothing expected: compensation %0d, estimate %0d",
                   rsp_compensation, rsp_disturbance_estimate);
         end else begin
            want = expected_estimates.pop_front();
            if (rsp_compensation !== want.compensation) begin
               mismatch_count++;
               $error("compensation: expected %0d, actual %0d",
                      $signed(want.compensation), rsp_compensation);
            end
            if (rsp_disturbance_estimate !== want.estimate) begin
               mismatch_count++;
               $error("disturbance_estimate: expected %0d, actual %0d",
                      $signed(want.estimate), rsp_disturbance_estimate);
            end
         end
      end
   end

   initial begin : stimulus
      logic signed [31:0] meas;
      logic signed [31:0] effort;
      logic [16:0]        dt;
      int                 current_setting;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      current_setting = 0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].setting != current_setting) begin
            wait_for_results();
            current_setting = directed_rows[i].setting;
            apply_settings(directed_settings[current_setting]);
         end
         send_beat(directed_rows[i].measurement, directed_rows[i].effort,
                   directed_rows[i].dt, directed_rows[i].known,
                   directed_rows[i].compensation, directed_rows[i].estimate);
      end
      wait_for_results();
      for (int phase = 0; phase < 8; phase++) begin
         apply_settings(random_settings());
         no_idle = (phase == 5);
         if (phase == 2) begin
            hold_results_request = 1'b1;
         end
         for (int i = 0; i < 100; i++) begin
            if (i == 50) begin
               wait_for_results();
            end
            next_random_beat(meas, effort, dt);
            send_beat(meas, effort, dt, 1'b0, 32'sd0, 32'sd0);
         end
         wait_for_results();
      end
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
design/ldo_pkg.sv
design/linear_disturbance_observer_top.sv
verif/linear_disturbance_observer_top_tb.sv
